[rtl/core/bfv_pkg.sv]
// shared types and constants for the box feature vertex generator
`default_nettype none
package bfv_pkg;

    localparam int COORD_W = 16;                 // q8.8 coordinates and q2.14 basis entries
    localparam int REG_W   = 3 * COORD_W;        // packed configuration register
    localparam int LOC_W   = COORD_W + 1;        // signed local coordinate, +/- half size
    localparam int PROD_W  = LOC_W + COORD_W;    // one basis product
    localparam int SUM_W   = PROD_W + 3;         // three products, centre and rounding half
    localparam int FRAC_SH = 14;                 // basis fraction bits dropped at the end
    localparam int CODE_W  = 7;
    localparam int TOTAL_W = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        FT_VERTEX = 2'd0,
        FT_EDGE   = 2'd1,
        FT_FACE   = 2'd2,
        FT_BAD    = 2'd3
    } t_feat_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_EXTENTS = 3'd0,
        CFG_BOX_CENTER   = 3'd1,
        CFG_BASIS_ROW_X  = 3'd2,
        CFG_BASIS_ROW_Y  = 3'd3,
        CFG_BASIS_ROW_Z  = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [TOTAL_W-1:0] TOTAL_NONE   = 3'd0;
    localparam logic [TOTAL_W-1:0] TOTAL_VERTEX = 3'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_EDGE   = 3'd2;
    localparam logic [TOTAL_W-1:0] TOTAL_FACE   = 3'd4;

    localparam logic [REG_W-1:0] BASIS_X_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] BASIS_Y_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] BASIS_Z_RST = 48'h4000_0000_0000;

    // control that travels with one point through the arithmetic stages
    typedef struct packed {
        logic [2:0]         pos;      // per axis: 1 = +half size, 0 = -half size
        logic [TOTAL_W-1:0] total;
        logic               invalid;
        logic               last;
    } t_pt_meta;

endpackage
`default_nettype wire

[rtl/core/bfv_if.sv]
// handshake channels of the box feature vertex generator
`default_nettype none
interface bfv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bfv_pkg::CFG_IDX_W-1:0]  index;
    logic [bfv_pkg::REG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface bfv_feat_if;
    logic                         valid;
    logic                         ready;
    logic [bfv_pkg::CODE_W-1:0]   feature_code;
    modport source (output valid, feature_code, input ready);
    modport sink   (input valid, feature_code, output ready);
endinterface

interface bfv_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [bfv_pkg::COORD_W-1:0]  point_x;
    logic signed [bfv_pkg::COORD_W-1:0]  point_y;
    logic signed [bfv_pkg::COORD_W-1:0]  point_z;
    logic [bfv_pkg::TOTAL_W-1:0]         point_total;
    logic                                code_invalid;
    logic                                last_point;
    modport source (output valid, point_x, point_y, point_z, point_total, code_invalid,
                    last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_total, code_invalid,
                    last_point, output ready);
endinterface
`default_nettype wire

[rtl/core/bfv_xform.sv]
// four stage point transform: local point, basis products, sum, round and saturate
`default_nettype none
module bfv_xform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bfv_pkg::REG_W-1:0]           i_half_extents,
    input  logic [bfv_pkg::REG_W-1:0]           i_box_center,
    input  logic [bfv_pkg::REG_W-1:0]           i_basis_row_x,
    input  logic [bfv_pkg::REG_W-1:0]           i_basis_row_y,
    input  logic [bfv_pkg::REG_W-1:0]           i_basis_row_z,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  bfv_pkg::t_pt_meta                   i_meta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bfv_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [bfv_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [bfv_pkg::COORD_W-1:0]  o_point_z,
    output bfv_pkg::t_pt_meta                   o_meta
);

    localparam int OUT_W = bfv_pkg::SUM_W - bfv_pkg::FRAC_SH;
    localparam logic signed [bfv_pkg::SUM_W-1:0] ROUND_HALF =
        bfv_pkg::SUM_W'(1) <<< (bfv_pkg::FRAC_SH - 1);
    localparam logic signed [OUT_W-1:0] SAT_MAX = OUT_W'(32767);
    localparam logic signed [OUT_W-1:0] SAT_MIN = -OUT_W'(32768);

    logic [bfv_pkg::REG_W-1:0] basis [3];

    logic                               r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    bfv_pkg::t_pt_meta                  r_b_meta, r_c_meta, r_d_meta, r_e_meta;
    logic signed [bfv_pkg::LOC_W-1:0]   r_b_p    [3];
    logic signed [bfv_pkg::LOC_W-1:0]   n_b_p    [3];
    logic signed [bfv_pkg::PROD_W-1:0]  r_c_prod [3][3];
    logic signed [bfv_pkg::PROD_W-1:0]  n_c_prod [3][3];
    logic signed [bfv_pkg::SUM_W-1:0]   r_d_sum  [3];
    logic signed [bfv_pkg::SUM_W-1:0]   n_d_sum  [3];
    logic signed [bfv_pkg::COORD_W-1:0] r_e_pt   [3];
    logic signed [bfv_pkg::COORD_W-1:0] n_e_pt   [3];

    logic take_b, take_c, take_d, take_e;

    assign basis[0] = i_basis_row_x;
    assign basis[1] = i_basis_row_y;
    assign basis[2] = i_basis_row_z;

    // a stage loads when it is empty or its contents move on this cycle
    assign take_e  = !r_e_valid || i_ready;
    assign take_d  = !r_d_valid || take_e;
    assign take_c  = !r_c_valid || take_d;
    assign take_b  = !r_b_valid || take_c;
    assign o_ready = take_b;

    always_comb begin
        logic signed [bfv_pkg::LOC_W-1:0] size;
        for (int j = 0; j < 3; j++) begin
            size = $signed({1'b0, i_half_extents[bfv_pkg::COORD_W*j +: bfv_pkg::COORD_W]});
            n_b_p[j] = i_meta.pos[j] ? size : -size;
        end
    end

    always_comb begin
        logic signed [bfv_pkg::COORD_W-1:0] coef;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef = $signed(basis[i][bfv_pkg::COORD_W*j +: bfv_pkg::COORD_W]);
                n_c_prod[i][j] = bfv_pkg::PROD_W'(r_b_p[i]) * bfv_pkg::PROD_W'(coef);
            end
        end
    end

    always_comb begin
        logic signed [bfv_pkg::COORD_W-1:0] ctr;
        for (int j = 0; j < 3; j++) begin
            ctr = $signed(i_box_center[bfv_pkg::COORD_W*j +: bfv_pkg::COORD_W]);
            n_d_sum[j] = bfv_pkg::SUM_W'(r_c_prod[0][j]) + bfv_pkg::SUM_W'(r_c_prod[1][j])
                       + bfv_pkg::SUM_W'(r_c_prod[2][j])
                       + (bfv_pkg::SUM_W'(ctr) <<< bfv_pkg::FRAC_SH) + ROUND_HALF;
        end
    end

    // floor by dropping fraction bits, clamp to 16 bits; invalid points give zero
    always_comb begin
        logic signed [OUT_W-1:0] fl;
        for (int j = 0; j < 3; j++) begin
            fl = $signed(r_d_sum[j][bfv_pkg::SUM_W-1:bfv_pkg::FRAC_SH]);
            if (r_d_meta.invalid) begin
                n_e_pt[j] = '0;
            end else if (fl > SAT_MAX) begin
                n_e_pt[j] = bfv_pkg::COORD_W'(SAT_MAX);
            end else if (fl < SAT_MIN) begin
                n_e_pt[j] = bfv_pkg::COORD_W'(SAT_MIN);
            end else begin
                n_e_pt[j] = fl[bfv_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (take_b) r_b_valid <= i_valid;
            if (take_c) r_c_valid <= r_b_valid;
            if (take_d) r_d_valid <= r_c_valid;
            if (take_e) r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_b) begin
            r_b_meta <= i_meta;
            r_b_p    <= n_b_p;
        end
        if (take_c) begin
            r_c_meta <= r_b_meta;
            r_c_prod <= n_c_prod;
        end
        if (take_d) begin
            r_d_meta <= r_c_meta;
            r_d_sum  <= n_d_sum;
        end
        if (take_e) begin
            r_e_meta <= r_d_meta;
            r_e_pt   <= n_e_pt;
        end
    end

    assign o_valid   = r_e_valid;
    assign o_meta    = r_e_meta;
    assign o_point_x = r_e_pt[0];
    assign o_point_y = r_e_pt[1];
    assign o_point_z = r_e_pt[2];

endmodule
`default_nettype wire

[rtl/core/box_feature_vertices.sv]
// top level: feature code sequencer, configuration registers and point transform
//
//  channel   dir  payload                                         handshake
//  i_cfg     in   index[2:0], data[47:0]                          valid/ready
//  i_feat    in   feature_code[6:0]                               valid/ready
//  o_point   out  point_x/y/z[15:0], point_total, code_invalid,   valid/ready
//                 last_point
//
// the sequencer issues one point per cycle while the transform is ready: a vertex gives one
// point, an edge two, a face four, a bad code one; the issue slot is the throughput limit,
// the next code is taken as the last point of the current one issues
// from input beat to first output beat a point passes the sequencer and the 4 stages
// synchronous active-low reset empties the pipeline and loads the identity basis
// a stalled output backs up stage by stage; bubbles still fill, so input keeps flowing until the stages are full
`default_nettype none
module box_feature_vertices (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bfv_cfg_if.sink            i_cfg,
    bfv_feat_if.sink           i_feat,
    bfv_point_if.source        o_point
);

    logic [bfv_pkg::REG_W-1:0]  r_half_extents, r_box_center;
    logic [bfv_pkg::REG_W-1:0]  r_basis_row_x, r_basis_row_y, r_basis_row_z;

    logic                        r_seq_valid;
    logic [bfv_pkg::CODE_W-1:0]  r_code;
    logic [1:0]                  r_k;
    bfv_pkg::t_pt_meta           seq_meta;
    bfv_pkg::t_pt_meta           out_meta;
    logic                        xf_ready;
    logic                        seq_fire;
    logic                        feat_acc;

    // place the on-axis sign and the two side signs on their axes
    function automatic logic [2:0] rot_pos(logic [1:0] az, logic s_a, logic s_b, logic s_c);
        logic [2:0] p;
        p = '0;
        unique case (az)
            2'd0:    p = {s_c, s_b, s_a};
            2'd1:    p = {s_b, s_a, s_c};
            2'd2:    p = {s_a, s_c, s_b};
            default: p = '0;
        endcase
        return p;
    endfunction

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_extents <= '0;
            r_box_center   <= '0;
            r_basis_row_x  <= bfv_pkg::BASIS_X_RST;
            r_basis_row_y  <= bfv_pkg::BASIS_Y_RST;
            r_basis_row_z  <= bfv_pkg::BASIS_Z_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bfv_pkg::CFG_HALF_EXTENTS: r_half_extents <= i_cfg.data;
                bfv_pkg::CFG_BOX_CENTER:   r_box_center   <= i_cfg.data;
                bfv_pkg::CFG_BASIS_ROW_X:  r_basis_row_x  <= i_cfg.data;
                bfv_pkg::CFG_BASIS_ROW_Y:  r_basis_row_y  <= i_cfg.data;
                bfv_pkg::CFG_BASIS_ROW_Z:  r_basis_row_z  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // point decode for slot r_k of the held code
    always_comb begin
        logic [1:0] az;
        logic [1:0] fi;
        logic       plus;
        seq_meta.pos     = '0;
        seq_meta.total   = bfv_pkg::TOTAL_NONE;
        seq_meta.invalid = 1'b1;
        seq_meta.last    = 1'b1;
        az   = '0;
        fi   = '0;
        plus = r_code[0];
        unique case (bfv_pkg::t_feat_type'(r_code[6:5]))
            bfv_pkg::FT_VERTEX: begin
                seq_meta.pos     = r_code[2:0];
                seq_meta.total   = bfv_pkg::TOTAL_VERTEX;
                seq_meta.invalid = 1'b0;
            end
            bfv_pkg::FT_EDGE: begin
                az = r_code[3:2];
                if (az != bfv_pkg::AXIS_NONE) begin
                    // first point at -size on the edge axis, second at +size
                    seq_meta.pos     = rot_pos(az, r_k[0], r_code[0], r_code[1]);
                    seq_meta.total   = bfv_pkg::TOTAL_EDGE;
                    seq_meta.invalid = 1'b0;
                    seq_meta.last    = r_k[0];
                end
            end
            bfv_pkg::FT_FACE: begin
                az = r_code[2:1];
                if (az != bfv_pkg::AXIS_NONE) begin
                    // slot order flips with the side so the winding stays outward
                    fi = r_k ^ (plus ? 2'b01 : 2'b11);
                    seq_meta.pos     = rot_pos(az, plus, fi[0] == fi[1], !fi[1]);
                    seq_meta.total   = bfv_pkg::TOTAL_FACE;
                    seq_meta.invalid = 1'b0;
                    seq_meta.last    = (r_k == 2'd3);
                end
            end
            bfv_pkg::FT_BAD: ;
        endcase
    end

    assign seq_fire     = r_seq_valid && xf_ready;
    assign i_feat.ready = !r_seq_valid || (seq_fire && seq_meta.last);
    assign feat_acc     = i_feat.valid && i_feat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_k         <= '0;
        end else if (feat_acc) begin
            r_seq_valid <= 1'b1;
            r_k         <= '0;
        end else if (seq_fire) begin
            if (seq_meta.last) begin
                r_seq_valid <= 1'b0;
            end
            r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (feat_acc) begin
            r_code <= i_feat.feature_code;
        end
    end

    bfv_xform u_xform (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_half_extents (r_half_extents),
        .i_box_center   (r_box_center),
        .i_basis_row_x  (r_basis_row_x),
        .i_basis_row_y  (r_basis_row_y),
        .i_basis_row_z  (r_basis_row_z),
        .i_valid        (r_seq_valid),
        .o_ready        (xf_ready),
        .i_meta         (seq_meta),
        .o_valid        (o_point.valid),
        .i_ready        (o_point.ready),
        .o_point_x      (o_point.point_x),
        .o_point_y      (o_point.point_y),
        .o_point_z      (o_point.point_z),
        .o_meta         (out_meta)
    );

    assign o_point.point_total  = out_meta.total;
    assign o_point.code_invalid = out_meta.invalid;
    assign o_point.last_point   = out_meta.last;

    // the slot counter never runs past the point count of the held code
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_valid && !seq_meta.invalid) |-> ({1'b0, r_k} < seq_meta.total))
        else $error("sequencer slot beyond feature point count");

    // a new code starts at slot zero
    a_fresh_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        feat_acc |=> (r_seq_valid && r_k == 2'd0))
        else $error("accepted code not loaded at slot zero");

    // a bad code comes out as one zero point that closes the item
    a_invalid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && o_point.code_invalid) |->
        (o_point.last_point && o_point.point_total == bfv_pkg::TOTAL_NONE &&
         o_point.point_x == '0 && o_point.point_y == '0 && o_point.point_z == '0))
        else $error("invalid beat carries data");

    // good beats carry one of the three point counts
    a_total_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && !o_point.code_invalid) |->
        (o_point.point_total == bfv_pkg::TOTAL_VERTEX ||
         o_point.point_total == bfv_pkg::TOTAL_EDGE ||
         o_point.point_total == bfv_pkg::TOTAL_FACE))
        else $error("bad point count on valid beat");

endmodule
`default_nettype wire
